FILE: sv/lmrle_pkg.sv
// Package: shared types and constants of the label map run-length encoder.
package lmrle_pkg;

  localparam int LabelW   = 32;
  localparam int WidthW   = 13;
  localparam int LbitsW   = 6;
  localparam int RunMax   = 255;
  localparam int CodeW    = 64;
  localparam int CodeLenW = 7;

  localparam logic [2:0] ADDR_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_LBITS = 3'd4;

  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_EXTEND = 2'd1;
  localparam logic [1:0] KIND_BREAK  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [LabelW-1:0] label;
    logic              fin;
  } cmd_t;

  typedef struct packed {
    logic [CodeW-1:0]    bits;
    logic [CodeLenW-1:0] len;
    logic                fin;
  } code_t;

endpackage

FILE: sv/lmrle_if.sv
// Interfaces: valid/ready channels for pixel and byte words.
interface lmrle_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] label;
  logic        final_pixel;
  modport source (output valid, label, final_pixel, input ready);
  modport sink (input valid, label, final_pixel, output ready);
endinterface

interface lmrle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_end;
  modport source (output valid, out_byte, run_last, stream_end, input ready);
  modport sink (input valid, out_byte, run_last, stream_end, output ready);
endinterface

FILE: sv/label_map_run_length_encoder.sv
// Top level: label map run-length encoder with upper-row context.
// One pixel word a cycle is taken into a four-deep queue while the queue has room; the back end
// reads a command, walks the upper-row entries on a label change outside the first row, emits
// the code and hands it to the packer. The packer loads a code, then shifts it out in byte-aligned
// chunks, emits at most one byte word per cycle and holds a pixel's code until its bytes are out.
// Run-extending pixels give no byte. The upper-row store is a single-port RAM of
// MAX_WIDTH labels.
module label_map_run_length_encoder #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  lmrle_pix_if.sink   in_pix,
  lmrle_byte_if.source out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [12:0] width_r;
  logic [5:0]  lbits_r;
  logic        q_valid, q_ready, c_valid, c_ready, f_valid, f_ready;
  lmrle_pkg::cmd_t  q_cmd, f_cmd;
  lmrle_pkg::code_t code;

  assign pready = 1'b1;
  assign prdata = (paddr == lmrle_pkg::ADDR_LBITS) ? 32'(lbits_r) : 32'(width_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd4096; lbits_r <= 6'd32;
    end else if (psel && penable && pwrite) begin
      if (paddr == lmrle_pkg::ADDR_WIDTH) width_r <= pwdata[12:0];
      else if (paddr == lmrle_pkg::ADDR_LBITS) lbits_r <= pwdata[5:0];
    end
  end

  lmrle_front u_front (.clk, .rst_n, .label_bits(lbits_r), .pix(in_pix),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd));
  lmrle_fifo #(.Depth(4)) u_fifo (.clk, .rst_n, .wr_valid(q_valid), .wr_ready(q_ready),
    .wr_data(q_cmd), .rd_valid(f_valid), .rd_ready(f_ready), .rd_data(f_cmd));
  lmrle_back #(.MaxWidth(MAX_WIDTH)) u_back (.clk, .rst_n, .image_width(width_r),
    .label_bits(lbits_r), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd),
    .code_valid(c_valid), .code_ready(c_ready), .code(code));
  lmrle_pack u_pack (.clk, .rst_n, .code_valid(c_valid), .code_ready(c_ready), .code(code),
    .outp(out_res));
endmodule

FILE: sv/lmrle_front.sv
// Front end: masks labels, classifies each word as first, extend or break.
module lmrle_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [5:0]                 label_bits,
  lmrle_pix_if.sink                  pix,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output lmrle_pkg::cmd_t            cmd
);
  logic [31:0] run_label_r, run_label_nxt;
  logic [7:0]  run_len_r, run_len_nxt;
  logic        started_r, started_nxt;
  logic [5:0]  nb;
  logic [31:0] mask, lab;
  logic        acc;

  assign nb   = (label_bits > 6'd32) ? 6'd32 : label_bits;
  assign mask = 32'((64'd1 << nb) - 64'd1);
  assign lab  = pix.label & mask;
  assign pix.ready = cmd_ready;
  assign cmd_valid = pix.valid;
  assign acc = pix.valid && cmd_ready;

  always_comb begin
    cmd.label = lab;
    cmd.fin   = pix.final_pixel;
    if (!started_r) begin
      cmd.kind = lmrle_pkg::KIND_FIRST;
    end else if (lab == run_label_r && run_len_r < 8'(lmrle_pkg::RunMax)) begin
      cmd.kind = lmrle_pkg::KIND_EXTEND;
    end else begin
      cmd.kind = lmrle_pkg::KIND_BREAK;
    end
    run_label_nxt = run_label_r;
    run_len_nxt   = run_len_r;
    started_nxt   = started_r;
    if (acc) begin
      if (cmd.kind == lmrle_pkg::KIND_EXTEND) begin
        run_len_nxt = run_len_r + 8'd1;
      end else begin
        run_len_nxt   = 8'd1;
        run_label_nxt = lab;
      end
      started_nxt = 1'b1;
      if (pix.final_pixel) begin
        started_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_label_r <= '0;
      run_len_r   <= '0;
      started_r   <= 1'b0;
    end else begin
      run_label_r <= run_label_nxt;
      run_len_r   <= run_len_nxt;
      started_r   <= started_nxt;
    end
  end
endmodule

FILE: sv/lmrle_fifo.sv
// Queue: small FIFO of classified commands between front and back.
module lmrle_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  lmrle_pkg::cmd_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output lmrle_pkg::cmd_t rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  lmrle_pkg::cmd_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;

  assign wr_ready = cnt_r != (AW+1)'(Depth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

FILE: sv/lmrle_back.sv
// Back end: upper-row store, context walk, code building.
module lmrle_back #(
  parameter int MaxWidth = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [12:0]           image_width,
  input  logic [5:0]            label_bits,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  lmrle_pkg::cmd_t       cmd,
  output logic                  code_valid,
  input  logic                  code_ready,
  output lmrle_pkg::code_t      code
);
  localparam int CW = $clog2(MaxWidth + 1);
  localparam int AW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ABOVE = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [1:0] CTX_NONE  = 2'd0;
  localparam logic [1:0] CTX_ABOVE = 2'd1;
  localparam logic [1:0] CTX_RIGHT = 2'd2;

  logic [31:0]   mem_r [MaxWidth];
  logic [31:0]   rd_r;
  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] col_r, col_nxt, j_r, j_nxt;
  logic          first_row_r, first_row_nxt;
  logic [31:0]   largest_r, largest_nxt, above_r, above_nxt;
  logic [7:0]    run_len_r, run_len_nxt, len_cl_r, len_cl_nxt;
  lmrle_pkg::cmd_t cur_r, cur_nxt;
  lmrle_pkg::code_t code_r, code_nxt;
  logic [1:0]    ctx_r, ctx_nxt;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] width, colx;
  logic [5:0]    nb;
  logic          wr_en;

  assign nb = (label_bits > 6'd32) ? 6'd32 : label_bits;
  always_comb begin
    if (image_width == 13'd0) begin
      width = CW'(1);
    end else if (32'(image_width) > MaxWidth) begin
      width = CW'(MaxWidth);
    end else begin
      width = CW'(image_width);
    end
  end
  assign colx = (32'(col_r) >= MaxWidth) ? '0 : col_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[colx[AW-1:0]] <= cur_r.label;
    end
    if (rd_en) begin
      rd_r <= mem_r[rd_addr];
    end
  end

  function automatic logic [63:0] len_bits(input logic [7:0] l, output logic [3:0] n);
    if (l >= 8'd1 && l <= 8'd4) begin
      n = 4'd3;
      len_bits = 64'(l - 8'd1);
    end else begin
      n = 4'd9;
      len_bits = 64'd256 + 64'(l);
    end
  endfunction

  assign cmd_ready  = st_r == S_IDLE;
  assign code_valid = st_r == S_OUT;
  assign code = code_r;

  always_comb begin
    logic [63:0] lb, lab_code;
    logic [3:0]  ln;
    logic [6:0]  labn;
    st_nxt = st_r; col_nxt = col_r; j_nxt = j_r; first_row_nxt = first_row_r;
    largest_nxt = largest_r; above_nxt = above_r; run_len_nxt = run_len_r;
    len_cl_nxt = len_cl_r; cur_nxt = cur_r; code_nxt = code_r; ctx_nxt = ctx_r;
    rd_en = 1'b0; rd_addr = colx[AW-1:0]; wr_en = 1'b0;
    lb = '0; ln = '0; lab_code = '0; labn = '0;
    case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cur_nxt = cmd;
          len_cl_nxt = run_len_r;
          rd_en = 1'b1;
          ctx_nxt = CTX_NONE;
          if (cmd.kind == lmrle_pkg::KIND_BREAK && !first_row_r) begin
            st_nxt = S_ABOVE;
          end else begin
            st_nxt = S_EMIT;
          end
        end
      end
      S_ABOVE: begin
        above_nxt = rd_r;
        if (rd_r == cur_r.label) begin
          ctx_nxt = CTX_ABOVE;
          st_nxt = S_EMIT;
        end else begin
          j_nxt = colx + CW'(1);
          if (colx + CW'(1) < width) begin
            rd_en = 1'b1;
            rd_addr = AW'(colx + CW'(1));
            st_nxt = S_WALK;
          end else begin
            st_nxt = S_EMIT;
          end
        end
      end
      S_WALK: begin
        if (rd_r != above_r) begin
          if (rd_r == cur_r.label) begin
            ctx_nxt = CTX_RIGHT;
          end
          st_nxt = S_EMIT;
        end else if (j_r + CW'(1) < width) begin
          j_nxt = j_r + CW'(1);
          rd_en = 1'b1;
          rd_addr = AW'(j_r + CW'(1));
        end else begin
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        labn = 7'(nb) + 7'd3;
        lab_code = (64'd7 << nb) | 64'(cur_r.label);
        code_nxt.bits = '0;
        code_nxt.len = '0;
        if (cur_r.kind == lmrle_pkg::KIND_FIRST) begin
          code_nxt.bits = lab_code; code_nxt.len = labn;
          run_len_nxt = 8'd1;
          largest_nxt = cur_r.label;
        end else if (cur_r.kind == lmrle_pkg::KIND_EXTEND) begin
          run_len_nxt = run_len_r + 8'd1;
        end else begin
          lb = len_bits(len_cl_r, ln);
          if (ctx_r == CTX_ABOVE) begin
            code_nxt.bits = (lb << 1); code_nxt.len = 7'(ln) + 7'd1;
          end else if (ctx_r == CTX_RIGHT) begin
            code_nxt.bits = (lb << 2) | 64'd2; code_nxt.len = 7'(ln) + 7'd2;
          end else if (cur_r.label - largest_r == 32'd1) begin
            code_nxt.bits = (lb << 3) | 64'd6; code_nxt.len = 7'(ln) + 7'd3;
          end else begin
            code_nxt.bits = (lb << labn) | lab_code; code_nxt.len = 7'(ln) + labn;
          end
          run_len_nxt = 8'd1;
          if (largest_r < cur_r.label) begin
            largest_nxt = cur_r.label;
          end
        end
        wr_en = 1'b1;
        if (colx + CW'(1) >= width) begin
          col_nxt = '0; first_row_nxt = 1'b0;
        end else begin
          col_nxt = colx + CW'(1);
        end
        code_nxt.fin = cur_r.fin;
        if (cur_r.fin) begin
          lb = len_bits(run_len_nxt, ln);
          code_nxt.bits = (code_nxt.bits << ln) | lb;
          code_nxt.len = code_nxt.len + 7'(ln);
          run_len_nxt = '0; largest_nxt = '0; col_nxt = '0; first_row_nxt = 1'b1;
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (code_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; col_r <= '0; first_row_r <= 1'b1;
      largest_r <= '0; run_len_r <= '0;
    end else begin
      st_r <= st_nxt; col_r <= col_nxt; first_row_r <= first_row_nxt;
      largest_r <= largest_nxt; run_len_r <= run_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt; above_r <= above_nxt; len_cl_r <= len_cl_nxt;
    cur_r <= cur_nxt; code_r <= code_nxt; ctx_r <= ctx_nxt;
  end
endmodule

FILE: sv/lmrle_pack.sv
// Packer: shifts codes MSB first into bytes and emits byte words.
module lmrle_pack (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             code_valid,
  output logic             code_ready,
  input  lmrle_pkg::code_t code,
  lmrle_byte_if.source     outp
);
  logic [63:0] bits_r, bits_nxt;
  logic [6:0]  left_r, left_nxt;
  logic        fin_r, fin_nxt, busy_r, busy_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ov_r, ov_nxt, ol_r, ol_nxt, oe_r, oe_nxt;

  assign code_ready = !busy_r;
  assign outp.valid = ov_r;
  assign outp.out_byte = ob_r;
  assign outp.run_last = ol_r;
  assign outp.stream_end = oe_r;

  always_comb begin
    logic [3:0]  take;
    logic [7:0]  chunk, merged;
    logic        last_bits;
    bits_nxt = bits_r; left_nxt = left_r; fin_nxt = fin_r; busy_nxt = busy_r;
    acc_nxt = acc_r; fill_nxt = fill_r;
    ob_nxt = ob_r; ov_nxt = ov_r; ol_nxt = ol_r; oe_nxt = oe_r;
    take = '0; chunk = '0; merged = '0; last_bits = 1'b0;
    if (ov_r && outp.ready) begin
      ov_nxt = 1'b0;
    end
    if (!busy_r && code_valid) begin
      bits_nxt = code.bits << (7'd64 - code.len);
      if (code.len == 7'd0) begin
        bits_nxt = '0;
      end
      left_nxt = code.len; fin_nxt = code.fin; busy_nxt = 1'b1;
    end else if (busy_r && !ov_nxt) begin
      take = (7'(8 - fill_r) < left_r) ? 4'(8 - fill_r) : 4'(left_r);
      chunk = bits_r[63:56] >> fill_r;
      merged = acc_r | (chunk & ~(8'hFF >> (fill_r + take)));
      last_bits = 7'(take) == left_r;
      bits_nxt = bits_r << take;
      left_nxt = left_r - 7'(take);
      if (fill_r + take == 4'd8 || (last_bits && fin_r && fill_r + take != 4'd0)) begin
        ob_nxt = merged; ov_nxt = 1'b1;
        // last word of the pixel: no further full byte can follow from this code
        ol_nxt = fin_r ? last_bits : (left_nxt < 7'd8);
        oe_nxt = fin_r && last_bits;
        acc_nxt = '0; fill_nxt = '0;
        if (last_bits) begin
          busy_nxt = 1'b0;
        end
      end else begin
        acc_nxt = merged; fill_nxt = fill_r + take;
        if (last_bits) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; ov_r <= 1'b0; acc_r <= '0; fill_r <= '0;
    end else begin
      busy_r <= busy_nxt; ov_r <= ov_nxt; acc_r <= acc_nxt; fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt; left_r <= left_nxt; fin_r <= fin_nxt;
    ob_r <= ob_nxt; ol_r <= ol_nxt; oe_r <= oe_nxt;
  end
endmodule

FILE: bench/tb_label_map_run_length_encoder.sv
// Testbench: random and directed label images against a bit-exact encoder predictor.
module tb_label_map_run_length_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxW = 4096;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } byte_word_t;

  class lmrle_scoreboard;
    logic [31:0] upper[MaxW];
    logic [31:0] run_lab, largest;
    int          run_len, col, free_bits;
    bit          first_row, started;
    logic [7:0]  pack;
    int          width_reg, bits_reg;
    byte_word_t  pending[$];
    logic [7:0]  fresh[$];
    int          errors;

    function new();
      width_reg = MaxW;
      bits_reg  = 32;
      errors    = 0;
      restart();
      pack      = 0;
      free_bits = 8;
    endfunction

    function void restart();
      run_lab = 0; run_len = 0; largest = 0; col = 0;
      first_row = 1; started = 0;
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxW) return MaxW;
      return width_reg;
    endfunction

    function int eff_bits();
      return bits_reg > 32 ? 32 : bits_reg;
    endfunction

    function void pack_bits(logic [63:0] v, int n);
      for (int i = n; i > 0; i--) begin
        pack[free_bits-1] = v[i-1];
        free_bits--;
        if (free_bits == 0) begin
          fresh.push_back(pack);
          pack = 0;
          free_bits = 8;
        end
      end
    endfunction

    function void pack_length(int len);
      if (len >= 1 && len <= 4) pack_bits(len - 1, 3);
      else pack_bits(64'd256 + (len & 255), 9);
    endfunction

    function void pack_direct(logic [31:0] lab);
      int nb;
      nb = eff_bits();
      pack_bits((64'd7 << nb) | {32'd0, lab}, nb + 3);
    endfunction

    function void pack_label(logic [31:0] lab, int w);
      logic [31:0] above;
      int j;
      if (!first_row) begin
        above = upper[col];
        if (above == lab) begin
          pack_bits(0, 1);
          return;
        end
        j = col + 1;
        while (j < w && upper[j] == above) j++;
        if (j < w && upper[j] == lab) begin
          pack_bits(2, 2);
          return;
        end
      end
      if (lab - largest == 32'd1) pack_bits(6, 3);
      else pack_direct(lab);
    endfunction

    function void note_pixel(logic [31:0] label, logic fin);
      logic [63:0] mask;
      logic [31:0] lab;
      int w;
      byte_word_t e;
      mask = (64'd1 << eff_bits()) - 1;
      lab  = label & mask[31:0];
      w    = eff_width();
      if (!started) begin
        pack_direct(lab);
        run_lab = lab; run_len = 1; largest = lab; started = 1;
      end else if (lab == run_lab && run_len < 255) begin
        run_len++;
      end else begin
        pack_length(run_len);
        pack_label(lab, w);
        run_lab = lab; run_len = 1;
        if (largest < lab) largest = lab;
      end
      upper[col] = lab;
      if (col + 1 >= w) begin
        col = 0;
        first_row = 0;
      end else begin
        col++;
      end
      if (fin) begin
        pack_length(run_len);
        if (free_bits < 8) begin
          fresh.push_back(pack);
          pack = 0;
          free_bits = 8;
        end
        restart();
      end
      while (fresh.size() > 0) begin
        e.data       = fresh.pop_front();
        e.run_last   = fresh.size() == 0;
        e.stream_end = e.run_last && fin;
        pending.push_back(e);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic run_last, logic stream_end);
      byte_word_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual byte %02h last %b end %b",
                 $realtime, data, run_last, stream_end);
        return;
      end
      e = pending.pop_front();
      if (e.data !== data || e.run_last !== run_last || e.stream_end !== stream_end) begin
        errors++;
        $display("%0t: expected byte %02h last %b end %b, actual byte %02h last %b end %b",
                 $realtime, e.data, e.run_last, e.stream_end, data, run_last, stream_end);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  lmrle_pix_if  pix();
  lmrle_byte_if res();

  label_map_run_length_encoder DUT (
    .clk(clk), .rst_n(rst_n), .in_pix(pix), .out_res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lmrle_scoreboard sb = new();
  int burst_left, pixels_sent, cyc;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && res.valid && res.ready)
      sb.check_byte(res.out_byte, res.run_last, res.stream_end);
    case ((cyc / 97) % 3)
      0: res.ready <= 1'b1;
      1: res.ready <= $urandom_range(0, 1);
      default: res.ready <= (cyc % 4) == 0;
    endcase
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == lmrle_pkg::ADDR_WIDTH) sb.width_reg = data & 32'h1FFF;
    else sb.bits_reg = data & 32'h3F;
  endtask

  task automatic send_pixel(logic [31:0] label, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix.valid <= 1'b1; pix.label <= label; pix.final_pixel <= fin;
    do @(posedge clk); while (!pix.ready);
    sb.note_pixel(label, fin);
    pixels_sent++;
  endtask

  // drain all words, then keep the pixel input idle while the back end clears
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (4 * (sb.eff_width() + 8) + 40) @(posedge clk);
  endtask

  task automatic configure(int w, int nb);
    write_reg(lmrle_pkg::ADDR_WIDTH, w);
    write_reg(lmrle_pkg::ADDR_LBITS, nb);
  endtask

  function automatic logic [31:0] pick_label();
    int r, w;
    w = sb.eff_width();
    r = $urandom_range(0, 99);
    if (r < 45) return sb.run_lab;
    if (r < 55 && !sb.first_row) return sb.upper[sb.col];
    if (r < 65 && !sb.first_row) return sb.upper[(sb.col + $urandom_range(1, 3)) % w];
    if (r < 75) return sb.largest + 1;
    if (r < 90) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  task automatic random_image();
    int len, w, nb;
    logic [31:0] lab;
    case ($urandom_range(0, 9))
      0: w = 0;
      1: w = 4096;
      2: w = 8191;
      default: w = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 7))
      0: nb = 0;
      1: nb = 63;
      2: nb = 1;
      3: nb = $urandom_range(0, 63);
      default: nb = 32;
    endcase
    configure(w, nb);
    if ($urandom_range(0, 19) == 0) begin
      lab = $urandom;
      len = $urandom_range(250, 300);
      for (int i = 0; i < len; i++) send_pixel(lab, i == len - 1);
    end else begin
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) send_pixel(pick_label(), i == len - 1);
    end
    settle();
  endtask

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    pix.valid <= 1'b0; pix.label <= '0; pix.final_pixel <= 1'b0;
    burst_left = 0;
    pixels_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset widths: every code in first row, direct label with all bits set
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_0001, 1'b1);
    settle();
    // width 4, 8-bit labels: above, right-of-above, largest plus one, direct
    configure(4, 8);
    send_pixel(5, 1'b0); send_pixel(5, 1'b0); send_pixel(6, 1'b0); send_pixel(7, 1'b0);
    send_pixel(5, 1'b0); send_pixel(6, 1'b0); send_pixel(8, 1'b0);
    send_pixel(32'h1234, 1'b0); send_pixel(32'h1234, 1'b1);
    settle();
    // zero label bits, zero width
    configure(0, 0);
    send_pixel(32'hDEAD_BEEF, 1'b0); send_pixel(3, 1'b0); send_pixel(1, 1'b1);
    settle();
    // out-of-range width and label bits
    configure(8191, 63);
    send_pixel(32'h8000_0000, 1'b0); send_pixel(32'h8000_0001, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b1);
    settle();

    while (pixels_sent < 300) random_image();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending.size() > 0)
        $display("%0t: expected %0d more words, actual none", $realtime, sb.pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
